>>> rtl/bmp_pkg.sv
// shared constants, command codes and control types of the binomial mod prime block
package bmp_pkg;

	localparam int DEFAULT_COUNT_BITS = 16;
	localparam int RES_BITS = 30;
	localparam int OUT_TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

	localparam logic [RES_BITS-1:0] PRIME_MOD = 30'd1000000007;
	localparam logic [RES_BITS-1:0] EXP_INIT = PRIME_MOD - 30'd2;

	// barrett constant floor(2^60 / M)
	localparam logic [63:0] MU_WIDE = (64'd1 << 60) / {34'd0, PRIME_MOD};
	localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];
	localparam logic [31:0] MOD_X1 = {2'b00, PRIME_MOD};
	localparam logic [31:0] MOD_X2 = {1'b0, PRIME_MOD, 1'b0};

	// multiplier operand pairs
	localparam logic [2:0] OP_ACC_IDX   = 3'd0;
	localparam logic [2:0] OP_FR_FNR    = 3'd1;
	localparam logic [2:0] OP_POW_BASE  = 3'd2;
	localparam logic [2:0] OP_BASE_BASE = 3'd3;
	localparam logic [2:0] OP_ACC_POW   = 3'd4;

	// multiplier result destinations
	localparam logic [2:0] DST_FACT = 3'd0;
	localparam logic [2:0] DST_DEN  = 3'd1;
	localparam logic [2:0] DST_POW  = 3'd2;
	localparam logic [2:0] DST_BASE = 3'd3;
	localparam logic [2:0] DST_ACC  = 3'd4;

	typedef struct packed {
		logic       load;
		logic       acc_init;
		logic       acc_zero;
		logic       mul_start;
		logic [2:0] mul_op;
		logic       mul_write;
		logic [2:0] mul_dst;
		logic       out_load;
	} bmp_cmd_t;

	typedef struct packed {
		logic sign;
		logic above;
		logic trivial;
		logic idx_top;
		logic exp_zero;
		logic exp_lsb;
		logic mul_done;
	} bmp_stat_t;

endpackage

>>> rtl/bmp_mulmod.sv
// four-stage modular multiplier with barrett reduction modulo 1000000007
module bmp_mulmod import bmp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [RES_BITS-1:0] a,
	input  logic [RES_BITS-1:0] b,
	output logic                done,
	output logic [RES_BITS-1:0] res
);

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [59:0]         p_s1;
	logic [30:0]         q_s2;
	logic [31:0]         plo_s2, plo_s3;
	logic [31:0]         qm_s3;
	logic [RES_BITS-1:0] res_s4;

	logic [61:0] qmu;
	logic [60:0] qm;
	logic [31:0] rem;

	assign qmu = 62'(p_s1[59:29]) * 62'(BARRETT_MU);
	assign qm  = 61'(q_s2) * 61'(PRIME_MOD);
	// true remainder is below 3M, so 32 bits hold it
	assign rem = plo_s3 - qm_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= 60'(a) * 60'(b);
		q_s2   <= qmu[61:31];
		plo_s2 <= p_s1[31:0];
		qm_s3  <= qm[31:0];
		plo_s3 <= plo_s2;
		if (rem >= MOD_X2) begin
			res_s4 <= RES_BITS'(rem - MOD_X2);
		end else if (rem >= MOD_X1) begin
			res_s4 <= RES_BITS'(rem - MOD_X1);
		end else begin
			res_s4 <= RES_BITS'(rem);
		end
	end

	assign done = v_s4;
	assign res  = res_s4;

endmodule

>>> rtl/bmp_datapath.sv
// operand registers, factorial counter, exponent register and shared multiplier
module bmp_datapath import bmp_pkg::*; #(
	parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bmp_cmd_t              cmd,
	input  logic [COUNT_BITS-1:0] top_count,
	input  logic [COUNT_BITS:0]   pick_count,
	output bmp_stat_t             stat,
	output logic [RES_BITS-1:0]   coefficient
);

	logic [COUNT_BITS-1:0] n_q, r_q, nr_q, idx_q;
	logic                  sign_q;
	logic [RES_BITS-1:0]   acc_q, fr_q, fnr_q, base_q, pow_q, exp_q, out_q;
	logic [RES_BITS-1:0]   op_a, op_b, mul_res;
	logic                  mul_done;

	always_comb begin
		case (cmd.mul_op)
			OP_ACC_IDX: begin
				op_a = acc_q;
				op_b = RES_BITS'(idx_q);
			end
			OP_FR_FNR: begin
				op_a = fr_q;
				op_b = fnr_q;
			end
			OP_POW_BASE: begin
				op_a = pow_q;
				op_b = base_q;
			end
			OP_BASE_BASE: begin
				op_a = base_q;
				op_b = base_q;
			end
			OP_ACC_POW: begin
				op_a = acc_q;
				op_b = pow_q;
			end
			default: begin
				op_a = acc_q;
				op_b = pow_q;
			end
		endcase
	end

	bmp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= top_count;
			r_q    <= pick_count[COUNT_BITS-1:0];
			nr_q   <= top_count - pick_count[COUNT_BITS-1:0];
			sign_q <= pick_count[COUNT_BITS];
		end
		if (cmd.acc_init) begin
			acc_q <= RES_BITS'(1);
			idx_q <= COUNT_BITS'(1);
		end else if (cmd.acc_zero) begin
			acc_q <= '0;
		end
		if (cmd.mul_write) begin
			case (cmd.mul_dst)
				DST_FACT: begin
					// acc now holds idx!, keep the two denominator factorials on the way
					acc_q <= mul_res;
					idx_q <= idx_q + COUNT_BITS'(1);
					if (idx_q == r_q) begin
						fr_q <= mul_res;
					end
					if (idx_q == nr_q) begin
						fnr_q <= mul_res;
					end
				end
				DST_DEN: begin
					base_q <= mul_res;
					pow_q  <= RES_BITS'(1);
					exp_q  <= EXP_INIT;
				end
				DST_POW: begin
					pow_q <= mul_res;
				end
				DST_BASE: begin
					base_q <= mul_res;
					exp_q  <= exp_q >> 1;
				end
				DST_ACC: begin
					acc_q <= mul_res;
				end
				default: begin
					acc_q <= mul_res;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_q <= acc_q;
		end
	end

	assign stat.sign     = sign_q;
	assign stat.above    = r_q > n_q;
	assign stat.trivial  = (r_q == '0) || (r_q == n_q);
	assign stat.idx_top  = idx_q == n_q;
	assign stat.exp_zero = exp_q == '0;
	assign stat.exp_lsb  = exp_q[0];
	assign stat.mul_done = mul_done;

	assign coefficient = out_q;

endmodule

>>> rtl/bmp_ctrl.sv
// controller state machine: sequences factorials, inversion and result hand-off
module bmp_ctrl import bmp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  bmp_stat_t stat,
	output bmp_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_CHECK      = 4'd1;
	localparam logic [3:0] ST_FACT_ISSUE = 4'd2;
	localparam logic [3:0] ST_FACT_WAIT  = 4'd3;
	localparam logic [3:0] ST_DEN_ISSUE  = 4'd4;
	localparam logic [3:0] ST_DEN_WAIT   = 4'd5;
	localparam logic [3:0] ST_POW_CHECK  = 4'd6;
	localparam logic [3:0] ST_POW_MWAIT  = 4'd7;
	localparam logic [3:0] ST_POW_SQ     = 4'd8;
	localparam logic [3:0] ST_POW_SWAIT  = 4'd9;
	localparam logic [3:0] ST_FIN_ISSUE  = 4'd10;
	localparam logic [3:0] ST_FIN_WAIT   = 4'd11;
	localparam logic [3:0] ST_OUT        = 4'd12;

	logic [3:0] state_q, state_d;
	logic       m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.sign || stat.above) begin
					cmd.acc_zero = 1'b1;
					state_d      = ST_OUT;
				end else if (stat.trivial) begin
					cmd.acc_init = 1'b1;
					state_d      = ST_OUT;
				end else begin
					cmd.acc_init = 1'b1;
					state_d      = ST_FACT_ISSUE;
				end
			end
			ST_FACT_ISSUE: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_ACC_IDX;
				state_d       = ST_FACT_WAIT;
			end
			ST_FACT_WAIT: begin
				if (stat.mul_done) begin
					cmd.mul_write = 1'b1;
					cmd.mul_dst   = DST_FACT;
					state_d       = stat.idx_top ? ST_DEN_ISSUE : ST_FACT_ISSUE;
				end
			end
			ST_DEN_ISSUE: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_FR_FNR;
				state_d       = ST_DEN_WAIT;
			end
			ST_DEN_WAIT: begin
				if (stat.mul_done) begin
					cmd.mul_write = 1'b1;
					cmd.mul_dst   = DST_DEN;
					state_d       = ST_POW_CHECK;
				end
			end
			ST_POW_CHECK: begin
				if (stat.exp_zero) begin
					state_d = ST_FIN_ISSUE;
				end else if (stat.exp_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op    = OP_POW_BASE;
					state_d       = ST_POW_MWAIT;
				end else begin
					state_d = ST_POW_SQ;
				end
			end
			ST_POW_MWAIT: begin
				if (stat.mul_done) begin
					cmd.mul_write = 1'b1;
					cmd.mul_dst   = DST_POW;
					state_d       = ST_POW_SQ;
				end
			end
			ST_POW_SQ: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_BASE_BASE;
				state_d       = ST_POW_SWAIT;
			end
			ST_POW_SWAIT: begin
				if (stat.mul_done) begin
					cmd.mul_write = 1'b1;
					cmd.mul_dst   = DST_BASE;
					state_d       = ST_POW_CHECK;
				end
			end
			ST_FIN_ISSUE: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = OP_ACC_POW;
				state_d       = ST_FIN_WAIT;
			end
			ST_FIN_WAIT: begin
				if (stat.mul_done) begin
					cmd.mul_write = 1'b1;
					cmd.mul_dst   = DST_ACC;
					state_d       = ST_OUT;
				end
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;

endmodule

>>> rtl/binomial_mod_prime_top.sv
// top level of the binomial coefficient modulo 1000000007 block
//
// input stream s_*: one item holds n (top_count) and r (pick_count, signed).
// output stream m_*: one item per input holds C(n, r) mod 1000000007.
// an item is taken when tvalid and tready are both high.
// items are worked one at a time. s_tready is high only while the block
// is idle; the next item is taken while a result still waits in the output
// register, so a stalled receiver holds up only the hand-off of the next result.
// negative r or r above n gives 0 and r equal to 0 or n gives 1, with m_tvalid
// rising in the same cycle that s_tready returns high for the next item.
// otherwise every modular multiply goes through one shared four-stage barrett
// multiplier, and each result is written back before the next multiply starts;
// n multiplies build the factorials, one the denominator, 30 squarings and 15
// multiplies with a check of each exponent bit the fermat inverse, then one more
// for the result.
// arst_n clears the controller and the output valid; no item is held across reset.
// the result is held in m_tdata with m_tvalid high until m_tready.
module binomial_mod_prime_top import bmp_pkg::*; #(
	parameter int COUNT_BITS = DEFAULT_COUNT_BITS,
	localparam int IN_TDATA_BITS = ((2 * COUNT_BITS + 1 + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// top_count, pick_count
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// coefficient
	output logic [OUT_TDATA_BITS-1:0] m_tdata
);

	bmp_cmd_t            cmd;
	bmp_stat_t           stat;
	logic [RES_BITS-1:0] coefficient;

	bmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bmp_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.top_count   (s_tdata[COUNT_BITS-1:0]),
		.pick_count  (s_tdata[2*COUNT_BITS:COUNT_BITS]),
		.stat        (stat),
		.coefficient (coefficient)
	);

	assign m_tdata = OUT_TDATA_BITS'(coefficient);

endmodule
